// ===== rtl/dual_key_debounce_short_press_core_defines.svh =====
// assertion macros used by the dual key debounce rtl
// no dependencies; included by files that carry concurrent checks
`ifndef DUAL_KEY_DEBOUNCE_SHORT_PRESS_CORE_DEFINES_SVH
`define DUAL_KEY_DEBOUNCE_SHORT_PRESS_CORE_DEFINES_SVH

// generic clocked check, disabled while the active-low reset is asserted
`define DKSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check on the house clock and reset names
`define DKSP_CHECK(lbl, prop, msg) \
    `DKSP_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/dksp_pkg.sv =====
// types and constants for the dual key debouncer with click detection
// no dependencies
package dksp_pkg;

    localparam int STABLE_W  = 4;
    localparam int HOLD_W    = 10;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 10;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_LIMIT  = 4'd1;

    localparam logic [STABLE_W-1:0] STABLE_COUNT_RST = 4'd3;
    localparam logic [HOLD_W-1:0]   CLICK_LIMIT_RST  = 10'd33;

    typedef struct packed {
        logic [STABLE_W-1:0] stable_limit;   // already forced to at least one
        logic [HOLD_W-1:0]   click_limit;
    } t_cfg;

    typedef struct packed {
        logic click;
        logic level;
    } t_key_res;

endpackage

// ===== rtl/dksp_ifs.sv =====
// handshake interfaces: sample ticks in, results out, register writes
// depends on dksp_pkg
interface dksp_in_if;
    logic valid;
    logic ready;
    logic key_one_level;
    logic key_one_valid;
    logic key_two_level;
    logic key_two_valid;

    modport source (output valid, key_one_level, key_one_valid, key_two_level,
                    key_two_valid, input ready);
    modport sink   (input valid, key_one_level, key_one_valid, key_two_level,
                    key_two_valid, output ready);
endinterface

interface dksp_out_if;
    logic valid;
    logic ready;
    logic key_one_click;
    logic key_two_click;
    logic key_one_stable;
    logic key_two_stable;

    modport source (output valid, key_one_click, key_two_click, key_one_stable,
                    key_two_stable, input ready);
    modport sink   (input valid, key_one_click, key_two_click, key_one_stable,
                    key_two_stable, output ready);
endinterface

interface dksp_cfg_if import dksp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dksp_key.sv =====
// per-key debounce, arming, hold counter and click decision
// depends on dksp_pkg and the assertion macro header
`include "dual_key_debounce_short_press_core_defines.svh"

module dksp_key
    import dksp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_tick,
    input  logic     i_lev,
    input  logic     i_valid,
    input  t_cfg     i_cfg,
    output t_key_res o_res
);

    logic                r_acc, n_acc;
    logic                r_cand, n_cand;
    logic [STABLE_W-1:0] r_rep, n_rep;
    logic                r_armed, n_armed;
    logic [HOLD_W-1:0]   r_hold, n_hold;

    logic [HOLD_W-1:0] hold_inc;
    logic              stable;
    logic              change;
    logic              click;

    always_comb begin
        hold_inc = (r_hold == HOLD_MAX) ? r_hold : r_hold + 1'b1;
        n_cand   = r_cand;
        n_rep    = r_rep;
        n_armed  = r_armed;
        n_acc    = r_acc;
        n_hold   = hold_inc;
        stable   = 1'b0;
        change   = 1'b0;
        click    = 1'b0;
        if (i_valid) begin
            n_cand = i_lev;
            if (i_lev != r_cand) begin
                n_rep = STABLE_W'(1);
            end else if (r_rep < i_cfg.stable_limit) begin
                n_rep = r_rep + 1'b1;
            end
            stable = (n_rep >= i_cfg.stable_limit);
            if (stable && !i_lev) begin
                n_armed = 1'b1;
            end
            change = stable && (i_lev != r_acc);
            if (change) begin
                n_acc = i_lev;
                if (i_lev) begin
                    n_hold = '0;
                end else begin
                    click = n_armed && (hold_inc < i_cfg.click_limit);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 1'b0;
            r_cand  <= 1'b0;
            r_rep   <= '0;
            r_armed <= 1'b0;
            r_hold  <= '0;
        end else if (i_tick) begin
            r_acc   <= n_acc;
            r_cand  <= n_cand;
            r_rep   <= n_rep;
            r_armed <= n_armed;
            r_hold  <= n_hold;
        end
    end

    assign o_res.click = i_tick && click;
    assign o_res.level = n_acc;

    `DKSP_CHECK(a_click_is_release, i_tick && o_res.click |-> r_acc && i_valid && !i_lev, "click without accepted release")
    `DKSP_CHECK(a_cand_follows, i_tick && i_valid |=> r_cand == $past(i_lev), "candidate level not taken from sample")
    `DKSP_CHECK(a_press_clears_hold, i_tick && change && i_lev |=> r_hold == '0 && r_acc, "accepted press did not clear hold")
    `DKSP_CHECK(a_idle_holds, !i_tick && i_rst_n |=> $stable(r_acc) && $stable(r_hold) && $stable(r_rep), "key state moved without a tick")

endmodule

// ===== rtl/dual_key_debounce_short_press_core.sv =====
// a result is registered and appears in the cycle after its sample tick is transferred
// throughput: one tick per cycle; the input is taken while the result register
// holds a finished result as long as the sink takes it in the same cycle
// reset: synchronous active low; clears key state and result valid,
// loads stable_count = 3 and click_limit = 33; no clearing pass
module dual_key_debounce_short_press_core
    import dksp_pkg::*;
#(
    parameter int NUM_KEYS = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dksp_in_if.sink    i_in,
    dksp_cfg_if.sink   i_cfg,
    dksp_out_if.source o_out
);

    logic [STABLE_W-1:0] r_stable_count;
    logic [HOLD_W-1:0]   r_click_limit;
    t_cfg                cfg;

    logic     r_out_valid;
    logic     r_click_one, r_click_two, r_stable_one, r_stable_two;
    logic     tick;
    t_key_res key_res [NUM_KEYS];

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_count <= STABLE_COUNT_RST;
            r_click_limit  <= CLICK_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_STABLE_COUNT: r_stable_count <= i_cfg.data[STABLE_W-1:0];
                REG_CLICK_LIMIT:  r_click_limit  <= i_cfg.data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // zero stable count behaves as one
    assign cfg.stable_limit = (r_stable_count == '0) ? STABLE_W'(1) : r_stable_count;
    assign cfg.click_limit  = r_click_limit;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign tick       = i_in.valid && i_in.ready;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        logic lev;
        logic vld;
        if (k == 0) begin : g_one
            assign lev = i_in.key_one_level;
            assign vld = i_in.key_one_valid;
        end else if (k == 1) begin : g_two
            assign lev = i_in.key_two_level;
            assign vld = i_in.key_two_valid;
        end else begin : g_extra
            assign lev = 1'b0;
            assign vld = 1'b0;
        end
        dksp_key u_key (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tick  (tick),
            .i_lev   (lev),
            .i_valid (vld),
            .i_cfg   (cfg),
            .o_res   (key_res[k])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_click_one  <= key_res[0].click;
            r_stable_one <= key_res[0].level;
            r_click_two  <= (NUM_KEYS > 1) ? key_res[NUM_KEYS > 1 ? 1 : 0].click : 1'b0;
            r_stable_two <= (NUM_KEYS > 1) ? key_res[NUM_KEYS > 1 ? 1 : 0].level : 1'b0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.key_one_click  = r_click_one;
    assign o_out.key_two_click  = r_click_two;
    assign o_out.key_one_stable = r_stable_one;
    assign o_out.key_two_stable = r_stable_two;

endmodule
